[src/smoothed_gain_bypass_mix_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the smoothed gain / bypass mix block.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_GAIN_BYPASS_MIX_TOP_ASSERT_SVH
`define SMOOTHED_GAIN_BYPASS_MIX_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SGBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SGBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SGBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SGBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/sgbm_pkg.sv]
// ----------------------------------------------------------------------------
// sgbm_pkg
// Widths and fixed-point constants of the smoothed gain / bypass mix block.
// ----------------------------------------------------------------------------
package sgbm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int ACC_W           = 32;
    localparam int COEF_W          = 16;
    localparam int LEVEL_W         = 15;
    localparam int FADE_W          = 15;

    localparam int LEVEL_SHIFT     = 16;
    localparam int STEP_FRAC       = 16;
    localparam int FADE_FRAC       = 14;
    localparam int MIX_FRAC        = 30;

    localparam logic [FADE_W-1:0]  FADE_ONE   = 15'd16384;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'd26214;
    localparam logic [COEF_W-1:0]  COEF_RESET = 16'd131;
    localparam logic [ACC_W-1:0]   MIX_ONE    = 32'h4000_0000;
    localparam logic [ACC_W-1:0]   LEVEL_TOP  = ACC_W'(LEVEL_MAX) << LEVEL_SHIFT;

endpackage

[src/sgbm_in_if.sv]
// ----------------------------------------------------------------------------
// sgbm_in_if
// Input channel: one stereo sample pair with target level and bypass fade.
// ----------------------------------------------------------------------------
interface sgbm_in_if #(
    parameter int SAMPLE_BITS = sgbm_pkg::SAMPLE_BITS_DEF
);
    import sgbm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic [LEVEL_W-1:0]            target_level;
    logic [FADE_W-1:0]             bypass_fade;

    modport source (
        output valid, sample_a, sample_b, target_level, bypass_fade,
        input  ready
    );
    modport sink (
        input  valid, sample_a, sample_b, target_level, bypass_fade,
        output ready
    );
endinterface

[src/sgbm_out_if.sv]
// ----------------------------------------------------------------------------
// sgbm_out_if
// Output channel: one scaled stereo sample pair.
// ----------------------------------------------------------------------------
interface sgbm_out_if #(
    parameter int SAMPLE_BITS = sgbm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_a;
    logic signed [SAMPLE_BITS-1:0] out_b;

    modport source (
        output valid, out_a, out_b,
        input  ready
    );
    modport sink (
        input  valid, out_a, out_b,
        output ready
    );
endinterface

[src/sgbm_cfg_if.sv]
// ----------------------------------------------------------------------------
// sgbm_cfg_if
// Configuration write channel for the smoothing coefficient.
// ----------------------------------------------------------------------------
interface sgbm_cfg_if;
    import sgbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] smoothing_coefficient;

    modport source (
        output valid, smoothing_coefficient,
        input  ready
    );
    modport sink (
        input  valid, smoothing_coefficient,
        output ready
    );
endinterface

[src/sgbm_mul.sv]
// ----------------------------------------------------------------------------
// sgbm_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sgbm_mul #(
    parameter int MA = 32,
    parameter int MB = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MA-1:0]   i_mcand,
    input  logic [MB-1:0]   i_mplier,
    output logic            o_done,
    output logic [MA+MB-1:0] o_prod
);
    localparam int CW = (MB > 1) ? $clog2(MB) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [MA-1:0] r_mcand;
    logic [MA-1:0] r_hi;
    logic [MB-1:0] r_lo;

    logic [MA:0]   w_sum;
    logic [MA-1:0] n_hi;
    logic [MB-1:0] n_lo;

    always_comb begin
        w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : {(MA+1){1'b0}});
        n_hi  = w_sum[MA:1];
        n_lo  = {w_sum[0], r_lo[MB-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy  <= 1'b1;
                r_done  <= 1'b0;
                r_cnt   <= CW'(MB - 1);
                r_mcand <= i_mcand;
                r_hi    <= '0;
                r_lo    <= i_mplier;
            end else if (r_busy) begin
                r_hi   <= n_hi;
                r_lo   <= n_lo;
                r_done <= (r_cnt == '0);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

[src/smoothed_gain_bypass_mix_top.sv]
// ----------------------------------------------------------------------------
// smoothed_gain_bypass_mix_top
// Stereo level trim with a one-pole smoothed gain and a bypass crossfade.
// i_in carries one sample pair plus target level and bypass fade per beat;
// o_out returns exactly one scaled pair per input beat, in order. i_cfg
// writes the smoothing coefficient (reset 131) and is always ready.
// One item is processed at a time. A valid item runs four bit-serial
// multiplies on shift-add units: 16 steps for the level update, 16 for the
// crossfade gain, then SAMPLE_BITS steps for both channels in parallel.
// An item with out-of-range fade or level yields a zero pair without running
// the multiplies and leaves the level alone.
// The result sits in an output register: a new item is taken while it waits.
// If the receiver stalls with a result still queued, the block holds the
// next finished result internally and stops accepting until it drains.
// Reset (synchronous, active low) clears the smoothed level to zero and
// restores the coefficient.
// ----------------------------------------------------------------------------
`include "smoothed_gain_bypass_mix_top_assert.svh"

module smoothed_gain_bypass_mix_top #(
    parameter int SAMPLE_BITS = sgbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgbm_in_if.sink     i_in,
    sgbm_out_if.source  o_out,
    sgbm_cfg_if.sink    i_cfg
);
    import sgbm_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int PW0 = ACC_W + COEF_W;
    localparam int PWS = ACC_W + SAMPLE_BITS;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_GAIN  = 7'b0000010,
        ST_FADE  = 7'b0000100,
        ST_MIX   = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [COEF_W-1:0]  r_coef;
    logic [ACC_W-1:0]   r_level;
    logic [SB-1:0]      r_sa;
    logic [SB-1:0]      r_sb;
    logic [FADE_W-1:0]  r_fade;
    logic               r_diff_neg;
    logic               r_d2_neg;
    logic [ACC_W-1:0]   r_mix;
    logic [SB-1:0]      r_res_a;
    logic [SB-1:0]      r_res_b;
    logic               r_out_valid;
    logic [SB-1:0]      r_out_a;
    logic [SB-1:0]      r_out_b;

    logic               w_accept;
    logic               w_in_ok;
    logic               w_load;
    logic [ACC_W-1:0]   w_target_q;
    logic               w_tgt_ge;
    logic [ACC_W-1:0]   w_diff_mag;
    logic               w_lvl_ge;
    logic [ACC_W-1:0]   w_d2_mag;
    logic [ACC_W-1:0]   w_step;
    logic [ACC_W:0]     w_lvl_sum;
    logic [ACC_W-1:0]   w_lvl_new;
    logic [PW0-FADE_FRAC-1:0] w_mix_t;
    logic [ACC_W-1:0]   w_mix;
    logic [SB-1:0]      w_mag_a;
    logic [SB-1:0]      w_mag_b;

    logic               w_start0;
    logic [ACC_W-1:0]   w_mcand0;
    logic [COEF_W-1:0]  w_mplier0;
    logic               w_done0;
    logic [PW0-1:0]     w_prod0;
    logic               w_start_ch;
    logic               w_done_a;
    logic               w_done_b;
    logic [PWS-1:0]     w_prod_a;
    logic [PWS-1:0]     w_prod_b;

    function automatic logic [SAMPLE_BITS-1:0] f_scale(
        input logic [PWS-1:0] prod,
        input logic           neg
    );
        logic [SAMPLE_BITS-1:0] mag;
        mag = {1'b0, prod[MIX_FRAC+SAMPLE_BITS-2:MIX_FRAC]};
        if (|prod[PWS-1:MIX_FRAC+SAMPLE_BITS-1]) begin
            return '0;
        end
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_in_ok     = (i_in.bypass_fade <= FADE_ONE) && (i_in.target_level <= LEVEL_MAX);
    assign w_load      = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_target_q = {1'b0, i_in.target_level, {LEVEL_SHIFT{1'b0}}};
        w_tgt_ge   = (w_target_q >= r_level);
        w_diff_mag = w_tgt_ge ? (w_target_q - r_level) : (r_level - w_target_q);

        w_lvl_ge   = (r_level >= MIX_ONE);
        w_d2_mag   = w_lvl_ge ? (r_level - MIX_ONE) : (MIX_ONE - r_level);

        w_step     = w_prod0[PW0-1:STEP_FRAC];
        w_lvl_sum  = r_diff_neg ? ({1'b0, r_level} - {1'b0, w_step})
                                : ({1'b0, r_level} + {1'b0, w_step});
        w_lvl_new  = w_lvl_sum[ACC_W] ? '0 : w_lvl_sum[ACC_W-1:0];

        w_mix_t    = w_prod0[PW0-1:FADE_FRAC];
        w_mix      = r_d2_neg ? (MIX_ONE - w_mix_t[ACC_W-1:0])
                              : (MIX_ONE + w_mix_t[ACC_W-1:0]);

        w_mag_a    = r_sa[SB-1] ? (~r_sa + 1'b1) : r_sa;
        w_mag_b    = r_sb[SB-1] ? (~r_sb + 1'b1) : r_sb;

        w_start0   = (w_accept && w_in_ok) || (r_state == ST_FADE);
        w_mcand0   = (r_state == ST_IDLE) ? w_diff_mag : w_d2_mag;
        w_mplier0  = (r_state == ST_IDLE) ? r_coef : {1'b0, r_fade};
        w_start_ch = (r_state == ST_SCALE);
    end

    // level update and crossfade gain share one unit
    sgbm_mul #(.MA(ACC_W), .MB(COEF_W)) u_mul_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start0),
        .i_mcand  (w_mcand0),
        .i_mplier (w_mplier0),
        .o_done   (w_done0),
        .o_prod   (w_prod0)
    );

    sgbm_mul #(.MA(ACC_W), .MB(SAMPLE_BITS)) u_mul_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_ch),
        .i_mcand  (r_mix),
        .i_mplier (w_mag_a),
        .o_done   (w_done_a),
        .o_prod   (w_prod_a)
    );

    sgbm_mul #(.MA(ACC_W), .MB(SAMPLE_BITS)) u_mul_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_ch),
        .i_mcand  (r_mix),
        .i_mplier (w_mag_b),
        .o_done   (w_done_b),
        .o_prod   (w_prod_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_coef      <= COEF_RESET;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_coef <= i_cfg.smoothing_coefficient;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_sa       <= $unsigned(i_in.sample_a);
                        r_sb       <= $unsigned(i_in.sample_b);
                        r_fade     <= i_in.bypass_fade;
                        r_diff_neg <= !w_tgt_ge;
                        if (w_in_ok) begin
                            r_state <= ST_GAIN;
                        end else begin
                            r_res_a <= '0;
                            r_res_b <= '0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_GAIN: begin
                    if (w_done0) begin
                        r_level <= w_lvl_new;
                        r_state <= ST_FADE;
                    end
                end
                ST_FADE: begin
                    r_d2_neg <= !w_lvl_ge;
                    r_state  <= ST_MIX;
                end
                ST_MIX: begin
                    if (w_done0) begin
                        r_mix   <= w_mix;
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_done_a) begin
                        r_res_a <= f_scale(w_prod_a, r_sa[SB-1]);
                        r_res_b <= f_scale(w_prod_b, r_sb[SB-1]);
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_out_a     <= r_res_a;
                r_out_b     <= r_res_b;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_a = $signed(r_out_a);
    assign o_out.out_b = $signed(r_out_b);

    `SGBM_ASSERT_NEXT(a_valid_start, i_clk, i_rst_n, w_accept && w_in_ok, r_state == ST_GAIN)
    `SGBM_ASSERT_NEXT(a_bad_zero, i_clk, i_rst_n, w_accept && !w_in_ok,
                      r_state == ST_DONE && r_res_a == '0 && r_res_b == '0)
    `SGBM_ASSERT_IMPL(a_level_bound, i_clk, i_rst_n, 1'b1, r_level <= LEVEL_TOP)
    `SGBM_ASSERT_IMPL(a_ch_lockstep, i_clk, i_rst_n, w_done_a, w_done_b && r_state == ST_WAIT)
    `SGBM_ASSERT_IMPL(a_gain_phase, i_clk, i_rst_n, w_done0,
                      r_state == ST_GAIN || r_state == ST_MIX)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the smoothed gain / bypass mix block. A queue of
// stereo pairs feeds a driver; each accepted beat is run through a local
// fixed-point model of the level smoother and crossfade gain, and the monitor
// checks every output beat against the oldest prediction. Phases sweep the
// smoothing coefficient; both sides idle at random and the receiver stalls
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench;
    import sgbm_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int SMAX = (1 << (SB - 1)) - 1;
    localparam int SMIN = -(1 << (SB - 1));
    localparam int PHASE_BEATS = 205;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic signed [SB-1:0] a;
        logic signed [SB-1:0] b;
        logic [LEVEL_W-1:0]   level;
        logic [FADE_W-1:0]    fade;
    } t_pair_item;

    typedef struct packed {
        logic signed [SB-1:0] a;
        logic signed [SB-1:0] b;
    } t_pair_out;

    logic i_clk;
    logic i_rst_n;

    sgbm_in_if  #(.SAMPLE_BITS(SB)) in_bus ();
    sgbm_out_if #(.SAMPLE_BITS(SB)) out_bus ();
    sgbm_cfg_if                     cfg_bus ();

    smoothed_gain_bypass_mix_top #(.SAMPLE_BITS(SB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // model state
    logic [ACC_W-1:0]  level_acc;
    logic [COEF_W-1:0] gain_coef;

    t_pair_item pending_pairs[$];
    t_pair_out  expected_pairs[$];
    t_pair_item cur_pair;
    logic [LEVEL_W-1:0] held_level;

    bit in_busy;
    bit in_fire;
    bit out_fire;
    bit tx_idle_on;
    bit rx_idle_on;
    int in_wait;
    int out_wait;
    int rx_hold;
    int result_count;
    int mismatch_count;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        $display("tb: mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic longint shift_toward_zero(input longint v, input int sh);
        if (v < 0) return -((-v) >>> sh);
        return v >>> sh;
    endfunction

    function automatic logic signed [SB-1:0] trim_sample(input logic signed [SB-1:0] x,
                                                       input longint mix);
        longint y;
        longint lim;
        lim = longint'(1) << (SB - 1);
        y = shift_toward_zero(longint'(x) * mix, MIX_FRAC);
        if (y >= lim || y <= -lim) y = 0;
        return y[SB-1:0];
    endfunction

    // one step of the level smoother, then the crossfade gain on both channels; an out-of-range beat gives a zero pair
    function automatic t_pair_out apply_gain(input t_pair_item it);
        t_pair_out r;
        longint s;
        longint mix;
        r = '0;
        if (it.fade > FADE_ONE || it.level > LEVEL_MAX) return r;
        s = longint'(level_acc);
        s = s + shift_toward_zero(((longint'(it.level) << LEVEL_SHIFT) - s)
                                  * longint'(gain_coef), STEP_FRAC);
        if (s < 0) s = 0;
        level_acc = s[ACC_W-1:0];
        mix = (longint'(1) << MIX_FRAC)
            + shift_toward_zero(longint'(it.fade) * (s - (longint'(1) << MIX_FRAC)),
                                FADE_FRAC);
        r.a = trim_sample(it.a, mix);
        r.b = trim_sample(it.b, mix);
        return r;
    endfunction

    function automatic t_pair_item make_pair(input int a, input int b,
                                             input int lvl, input int fd);
        t_pair_item r;
        r.a     = SB'(a);
        r.b     = SB'(b);
        r.level = LEVEL_W'(lvl);
        r.fade  = FADE_W'(fd);
        return r;
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return SB'(SMAX);
            1:       return SB'(SMIN);
            2:       return SB'(-1);
            3:       return SB'(1);
            default: return SB'($urandom);
        endcase
    endfunction

    // mostly valid beats with a target that lingers so the level settles
    function automatic t_pair_item rand_pair();
        t_pair_item r;
        int pick;
        r.a = rand_sample();
        r.b = rand_sample();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            r.level = LEVEL_W'($urandom_range(0, 32767));
            r.fade  = FADE_W'($urandom_range(16385, 32767));
        end else if (pick < 10) begin
            r.level = LEVEL_W'($urandom_range(26215, 32767));
            r.fade  = FADE_W'($urandom_range(0, 32767));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       held_level = '0;
                    1:       held_level = LEVEL_W'(16384);
                    2:       held_level = LEVEL_MAX;
                    default: held_level = LEVEL_W'($urandom_range(0, 26214));
                endcase
            end
            r.level = held_level;
            case ($urandom_range(0, 7))
                0:       r.fade = '0;
                1:       r.fade = FADE_ONE;
                default: r.fade = FADE_W'($urandom_range(0, 16384));
            endcase
        end
        return r;
    endfunction

    function automatic int draw_wait(input bit on);
        if (!on || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic write_coef(input logic [COEF_W-1:0] v);
        @(negedge i_clk);
        cfg_bus.valid                 <= 1'b1;
        cfg_bus.smoothing_coefficient <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        gain_coef = v;
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || in_busy || expected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // accept side: predict on input beats, check output beats
    always @(posedge i_clk) begin
        t_pair_out want;
        in_fire  = i_rst_n && in_bus.valid && in_bus.ready;
        out_fire = i_rst_n && out_bus.valid && out_bus.ready;
        if (in_fire) expected_pairs.push_back(apply_gain(cur_pair));
        if (out_fire) begin
            result_count++;
            if (expected_pairs.size() == 0) begin
                flag_mismatch($sformatf("beat %0d arrived with nothing pending",
                                        result_count));
            end else begin
                want = expected_pairs.pop_front();
                if (out_bus.out_a !== want.a)
                    flag_mismatch($sformatf("beat %0d out_a %0d, want %0d",
                                            result_count, out_bus.out_a, want.a));
                if (out_bus.out_b !== want.b)
                    flag_mismatch($sformatf("beat %0d out_b %0d, want %0d",
                                            result_count, out_bus.out_b, want.b));
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (in_fire) begin
            in_busy = 1'b0;
            in_wait = draw_wait(tx_idle_on);
        end
        if (!in_busy) begin
            if (in_wait > 0) begin
                in_wait--;
            end else if (pending_pairs.size() > 0) begin
                cur_pair = pending_pairs.pop_front();
                in_busy  = 1'b1;
            end
        end
        in_bus.valid        <= in_busy;
        in_bus.sample_a     <= cur_pair.a;
        in_bus.sample_b     <= cur_pair.b;
        in_bus.target_level <= cur_pair.level;
        in_bus.bypass_fade  <= cur_pair.fade;
    end

    // output ready, with a long hold-off twice in the run
    always @(negedge i_clk) begin
        if (out_fire) begin
            out_wait = draw_wait(rx_idle_on);
            if (result_count % 500 == 250) rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            out_bus.ready <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [COEF_W-1:0] next_coef;
        level_acc      = '0;
        gain_coef      = COEF_RESET;
        cur_pair       = '0;
        held_level     = '0;
        in_busy        = 1'b0;
        in_fire        = 1'b0;
        out_fire       = 1'b0;
        in_wait        = 0;
        out_wait       = 0;
        rx_hold        = 0;
        result_count   = 0;
        mismatch_count = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        in_bus.valid        = 1'b0;
        in_bus.sample_a     = '0;
        in_bus.sample_b     = '0;
        in_bus.target_level = '0;
        in_bus.bypass_fade  = '0;
        out_bus.ready       = 1'b0;
        cfg_bus.valid                 = 1'b0;
        cfg_bus.smoothing_coefficient = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on the reset coefficient
        pending_pairs.push_back(make_pair(0, 0, 0, 0));
        pending_pairs.push_back(make_pair(SMAX, SMIN, 0, 0));
        pending_pairs.push_back(make_pair(SMIN, SMAX, 26214, 16384));
        pending_pairs.push_back(make_pair(1, -1, 26214, 16384));
        pending_pairs.push_back(make_pair(SMAX, SMAX, 26215, 0));
        pending_pairs.push_back(make_pair(SMAX, SMIN, 0, 16385));
        pending_pairs.push_back(make_pair(-1, 1, 32767, 32767));
        pending_pairs.push_back(make_pair(5 << 20, -(5 << 20), 16384, 8192));
        pending_pairs.push_back(make_pair(32'h555555, 32'hAAAAAA, 21845, 10922));
        pending_pairs.push_back(make_pair(32'hAAAAAA, 32'h555555, 10922, 5461));
        pending_pairs.push_back(make_pair(SMAX, SMIN, 26214, 0));
        pending_pairs.push_back(make_pair(SMAX, SMIN, 0, 16384));
        pending_pairs.push_back(make_pair(SMIN, SMIN, 10000, 1));
        pending_pairs.push_back(make_pair(SMAX, -1, 26214, 16383));
        pending_pairs.push_back(make_pair(123456, -654321, 26214, 16384));
        pending_pairs.push_back(make_pair(SMAX / 2, SMIN / 2, 26214, 16384));
        pending_pairs.push_back(make_pair(0, SMAX, 16384, 16384));
        pending_pairs.push_back(make_pair(-2, 2, 26214, 32767));

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            case (p)
                0:       next_coef = 16'hFFFF;
                1:       next_coef = 16'h0000;
                2:       next_coef = 16'h0001;
                3:       next_coef = COEF_RESET;
                4:       next_coef = 16'h8000;
                default: next_coef = COEF_W'($urandom);
            endcase
            write_coef(next_coef);
            tx_idle_on = (p % 3) != 1;
            rx_idle_on = (p % 3) != 2;
            for (int i = 0; i < PHASE_BEATS; i++) pending_pairs.push_back(rand_pair());
        end

        wait_idle();
        repeat (SB + 40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pairs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/sgbm_pkg.sv
src/sgbm_in_if.sv
src/sgbm_out_if.sv
src/sgbm_cfg_if.sv
src/sgbm_mul.sv
src/smoothed_gain_bypass_mix_top.sv
tb/testbench.sv
